@@ hw/rtl/ukt_pkg.sv @@
// Shared types and constants for the unique-key table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ukt_pkg;

    localparam int KEY_W      = 32;
    localparam int TITLE_A_W  = 64;
    localparam int TITLE_B_W  = 64;
    localparam int TITLE_C_W  = 32;
    localparam int TITLE_IN_W = TITLE_A_W + TITLE_B_W + TITLE_C_W;
    localparam int STATUS_W   = 3;
    localparam int FILL_W     = 7;

    typedef enum logic {
        CMD_APPEND = 1'b0,
        CMD_SWAP   = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED   = 3'd0,
        ST_DUP     = 3'd1,
        ST_FULL    = 3'd2,
        ST_SWAPPED = 3'd3,
        ST_EMPTY   = 3'd4,
        ST_MISS_A  = 3'd5,
        ST_MISS_B  = 3'd6
    } t_status;

    // Port strobes from the sequencer to both memories
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage

`default_nettype wire

@@ hw/rtl/ukt_if.sv @@
// Request and response channel interfaces for the unique-key table.
// Depends on ukt_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ukt_req_if;
    logic                                valid;
    logic                                ready;
    logic                                cmd;
    logic signed [ukt_pkg::KEY_W-1:0]    key_a;
    logic signed [ukt_pkg::KEY_W-1:0]    key_b;
    logic [ukt_pkg::TITLE_A_W-1:0]       title_part_a;
    logic [ukt_pkg::TITLE_B_W-1:0]       title_part_b;
    logic [ukt_pkg::TITLE_C_W-1:0]       title_part_c;

    modport source (output valid, cmd, key_a, key_b, title_part_a, title_part_b,
                    title_part_c, input ready);
    modport sink (input valid, cmd, key_a, key_b, title_part_a, title_part_b,
                  title_part_c, output ready);
endinterface

interface ukt_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [ukt_pkg::STATUS_W-1:0]   status;
    logic [ukt_pkg::FILL_W-1:0]     fill_count;

    modport source (output valid, status, fill_count, input ready);
    modport sink (input valid, status, fill_count, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ukt_ram.sv @@
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on ukt_pkg for the port strobe struct.
`timescale 1ns / 1ps
`default_nettype none

module ukt_ram #(
    parameter int  DEPTH = 64,
    parameter int  WIDTH = 32,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire                      i_clk,
    input  ukt_pkg::t_mem_ctl        i_ctl,
    input  wire  [AW-1:0]            i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [AW-1:0]            i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/ukt_ctrl.sv @@
// Sequencer for the unique-key table: key scans, append and swap write-back.
// Depends on ukt_pkg and ukt_if; drives the key and title RAM ports.
`timescale 1ns / 1ps
`default_nettype none

module ukt_ctrl #(
    parameter int  CAPACITY    = 64,
    parameter int  TITLE_BYTES = 20,
    localparam int AW          = $clog2(CAPACITY),
    localparam int CW          = $clog2(CAPACITY + 1),
    localparam int TW          = 8 * TITLE_BYTES
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    ukt_req_if.sink                      i_req,
    ukt_rsp_if.source                    o_rsp,
    output ukt_pkg::t_mem_ctl            o_mem_ctl,
    output logic [AW-1:0]                o_raddr,
    output logic [AW-1:0]                o_waddr,
    output logic [ukt_pkg::KEY_W-1:0]    o_wkey,
    output logic [TW-1:0]                o_wtitle,
    input  wire  [ukt_pkg::KEY_W-1:0]    i_key_q,
    input  wire  [TW-1:0]                i_title_q,
    output logic [CW-1:0]                o_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_A,
        S_SCAN_B,
        S_ADD,
        S_RD_A,
        S_RD_B,
        S_WR_A,
        S_WR_B
    } t_state;

    t_state                         r_state;
    logic                           r_done;
    ukt_pkg::t_cmd                  r_cmd;
    logic [ukt_pkg::KEY_W-1:0]      r_key_a;
    logic [ukt_pkg::KEY_W-1:0]      r_key_b;
    logic [TW-1:0]                  r_title;
    logic [TW-1:0]                  r_title_a;
    logic [CW-1:0]                  r_count;
    logic [CW-1:0]                  r_scan;
    logic                           r_pend;
    logic [AW-1:0]                  r_pidx;
    logic [AW-1:0]                  r_ia;
    logic [AW-1:0]                  r_ib;
    ukt_pkg::t_status               r_status;
    logic                           r_ovalid;
    logic [ukt_pkg::STATUS_W-1:0]   r_ostatus;
    logic [ukt_pkg::FILL_W-1:0]     r_ofill;

    logic                           scanning;
    logic [ukt_pkg::KEY_W-1:0]      scan_key;
    logic                           hit;
    logic                           more;
    logic                           exhausted;
    logic [ukt_pkg::TITLE_IN_W-1:0] title_in;

    assign title_in  = {i_req.title_part_c, i_req.title_part_b, i_req.title_part_a};
    assign scanning  = (r_state == S_SCAN_A) || (r_state == S_SCAN_B);
    assign scan_key  = (r_state == S_SCAN_B) ? r_key_b : r_key_a;
    assign hit       = r_pend && (i_key_q == scan_key);
    assign more      = (r_scan < r_count);
    assign exhausted = !r_pend && !more;

    assign i_req.ready      = (r_state == S_IDLE) && !r_done;
    assign o_rsp.valid      = r_ovalid;
    assign o_rsp.status     = r_ostatus;
    assign o_rsp.fill_count = r_ofill;
    assign o_count          = r_count;

    always_comb begin
        o_mem_ctl.rd_en = (scanning && !hit && more) || (r_state == S_RD_A)
                          || (r_state == S_RD_B);
        o_mem_ctl.wr_en = (r_state == S_ADD) || (r_state == S_WR_A) || (r_state == S_WR_B);
        if (scanning) begin
            o_raddr = r_scan[AW-1:0];
        end else if (r_state == S_RD_A) begin
            o_raddr = r_ia;
        end else begin
            o_raddr = r_ib;
        end
        if (r_state == S_ADD) begin
            o_waddr  = r_count[AW-1:0];
            o_wkey   = r_key_a;
            o_wtitle = r_title;
        end else if (r_state == S_WR_A) begin
            o_waddr  = r_ia;
            o_wkey   = r_key_b;
            o_wtitle = i_title_q;
        end else begin
            o_waddr  = r_ib;
            o_wkey   = r_key_a;
            o_wtitle = r_title_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_done   <= 1'b0;
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            // finished request waits here for the response register
            if (r_done && (!r_ovalid || o_rsp.ready)) begin
                r_done    <= 1'b0;
                r_ovalid  <= 1'b1;
                r_ostatus <= r_status;
                r_ofill   <= ukt_pkg::FILL_W'(r_count);
            end else if (r_ovalid && o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid && !r_done) begin
                        r_cmd   <= ukt_pkg::t_cmd'(i_req.cmd);
                        r_key_a <= i_req.key_a;
                        r_key_b <= i_req.key_b;
                        r_title <= title_in[TW-1:0];
                        r_scan  <= '0;
                        r_pend  <= 1'b0;
                        if ((i_req.cmd == ukt_pkg::CMD_SWAP) && (r_count == '0)) begin
                            r_status <= ukt_pkg::ST_EMPTY;
                            r_done   <= 1'b1;
                        end else begin
                            r_state <= S_SCAN_A;
                        end
                    end
                end
                S_SCAN_A, S_SCAN_B: begin
                    if (hit) begin
                        r_pend <= 1'b0;
                        r_scan <= '0;
                        if (r_state == S_SCAN_B) begin
                            r_ib    <= r_pidx;
                            r_state <= S_RD_A;
                        end else if (r_cmd == ukt_pkg::CMD_APPEND) begin
                            r_status <= ukt_pkg::ST_DUP;
                            r_done   <= 1'b1;
                            r_state  <= S_IDLE;
                        end else begin
                            r_ia    <= r_pidx;
                            r_state <= S_SCAN_B;
                        end
                    end else if (exhausted) begin
                        if (r_state == S_SCAN_B) begin
                            r_status <= ukt_pkg::ST_MISS_B;
                            r_done   <= 1'b1;
                            r_state  <= S_IDLE;
                        end else if (r_cmd == ukt_pkg::CMD_SWAP) begin
                            r_status <= ukt_pkg::ST_MISS_A;
                            r_done   <= 1'b1;
                            r_state  <= S_IDLE;
                        end else if (r_count == CW'(CAPACITY)) begin
                            r_status <= ukt_pkg::ST_FULL;
                            r_done   <= 1'b1;
                            r_state  <= S_IDLE;
                        end else begin
                            r_state <= S_ADD;
                        end
                    end else if (more) begin
                        r_pend <= 1'b1;
                        r_pidx <= r_scan[AW-1:0];
                        r_scan <= r_scan + 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                    end
                end
                S_ADD: begin
                    r_count  <= r_count + 1'b1;
                    r_status <= ukt_pkg::ST_ADDED;
                    r_done   <= 1'b1;
                    r_state  <= S_IDLE;
                end
                S_RD_A: begin
                    r_state <= S_RD_B;
                end
                S_RD_B: begin
                    r_title_a <= i_title_q;
                    r_state   <= S_WR_A;
                end
                S_WR_A: begin
                    r_state <= S_WR_B;
                end
                S_WR_B: begin
                    r_status <= ukt_pkg::ST_SWAPPED;
                    r_done   <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/unique_key_table_append_swap_top.sv @@
// Top level of the unique-key table: sequencer plus key and title RAMs.
// Depends on ukt_pkg, ukt_if, ukt_ram and ukt_ctrl.
//
//   channel   dir  handshake               payload
//   i_req     in   valid/ready (interface) cmd, key_a, key_b, title_part_a/b/c
//   o_rsp     out  valid/ready (interface) status, fill_count
//
// An append scans the stored keys for key_a; a swap scans for key_a and then
// for key_b. One key is compared per cycle through the single read port of
// the key RAM, and a scan stops at the first match.
// Swap exchanges titles by two reads and two writes on the title RAM.
// Synchronous reset empties the table at once; RAM contents are not cleared.
// A new request is taken once the previous one is finished, even while its
// response is still held in the output register.
`timescale 1ns / 1ps
`default_nettype none

module unique_key_table_append_swap_top #(
    parameter int  CAPACITY    = 64,
    parameter int  TITLE_BYTES = 20,
    localparam int AW          = $clog2(CAPACITY),
    localparam int CW          = $clog2(CAPACITY + 1),
    localparam int TW          = 8 * TITLE_BYTES
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    ukt_req_if.sink    i_req,
    ukt_rsp_if.source  o_rsp
);

    ukt_pkg::t_mem_ctl           w_mem_ctl;
    logic [AW-1:0]               w_raddr;
    logic [AW-1:0]               w_waddr;
    logic [ukt_pkg::KEY_W-1:0]   w_wkey;
    logic [TW-1:0]               w_wtitle;
    logic [ukt_pkg::KEY_W-1:0]   w_key_q;
    logic [TW-1:0]               w_title_q;
    logic [CW-1:0]               w_count;

    ukt_ctrl #(
        .CAPACITY    (CAPACITY),
        .TITLE_BYTES (TITLE_BYTES)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .o_mem_ctl (w_mem_ctl),
        .o_raddr   (w_raddr),
        .o_waddr   (w_waddr),
        .o_wkey    (w_wkey),
        .o_wtitle  (w_wtitle),
        .i_key_q   (w_key_q),
        .i_title_q (w_title_q),
        .o_count   (w_count)
    );

    ukt_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (ukt_pkg::KEY_W)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_ctl   (w_mem_ctl),
        .i_waddr (w_waddr),
        .i_wdata (w_wkey),
        .i_raddr (w_raddr),
        .o_rdata (w_key_q)
    );

    ukt_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (TW)
    ) u_title_ram (
        .i_clk   (i_clk),
        .i_ctl   (w_mem_ctl),
        .i_waddr (w_waddr),
        .i_wdata (w_wtitle),
        .i_raddr (w_raddr),
        .o_rdata (w_title_q)
    );

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_write_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_ctl.wr_en |-> !i_req.ready)
        else $error("RAM write while accepting requests");

    a_count_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (w_count == $past(w_count))
            || ((w_count == $past(w_count) + 1'b1) && $past(w_mem_ctl.wr_en)))
        else $error("entry count changed without a single append");

endmodule

`default_nettype wire
